// ----- hdl/deq_pkg.sv -----
// Package for the deque with search: sizes, operation and status codes,
// cell control types and controller state type. No dependencies.
package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    typedef logic signed [VALUE_W-1:0] value_t;

    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] OP_SEARCH     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW    = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY_SEARCH = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW     = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       load;
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } ctrl_state_t;

endpackage

// ----- hdl/deq_cell.sv -----
// One storage cell of the deque chain: holds one entry, loads the item
// value, or takes its neighbor's entry. Depends on deq_pkg.
module deq_cell (
    input  logic                aclk,
    input  deq_pkg::cell_ctrl_t ctrl,
    input  deq_pkg::value_t     load_data,
    input  deq_pkg::value_t     prev_data,
    input  deq_pkg::value_t     next_data,
    output deq_pkg::value_t     data
);
    import deq_pkg::*;

    value_t data_reg;
    value_t data_next;

    always_comb begin
        case (ctrl.mode)
            CELL_HOLD:      data_next = ctrl.load ? load_data : data_reg;
            CELL_FROM_PREV: data_next = prev_data;
            CELL_FROM_NEXT: data_next = next_data;
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- hdl/deque_with_search.sv -----
// Deque with search: a chain of DEPTH cells, the front entry in cell 0.
// Push and pop: the result is registered in the cycle after the item is accepted.
// Search: the chain rotates one place a cycle and cell 0 is compared with the
// key, so a non-empty search gives its result after a full rotation; it blocks new items.
// Empty search answers like push or pop; push or pop 1/cycle while results are taken.
// Reset (aresetn low, synchronous) empties the queue and clears control state.
module deque_with_search (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [deq_pkg::FUNC_W-1:0]   s_func,
    input  deq_pkg::value_t              s_item_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [deq_pkg::STAT_W-1:0]   m_status,
    output logic                         m_found,
    output logic [deq_pkg::OCC_W-1:0]    m_occupancy
);
    import deq_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] step_reg, step_next;
    value_t           key_reg, key_next;
    logic             found_reg, found_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic              out_found_reg, out_found_next;

    cell_ctrl_t cell_ctrl [DEPTH];
    value_t     cell_data [DEPTH];

    logic accept;
    logic is_full;
    logic is_empty;
    logic last_step;
    logic search_hit;
    cell_mode_t chain_mode;

    assign is_full    = (count_reg >= CNT_W'(DEPTH));
    assign is_empty   = (count_reg == '0);
    assign last_step  = (step_reg == IDX_W'(DEPTH - 1));
    assign search_hit = ({1'b0, step_reg} < count_reg) && (cell_data[0] == key_reg);
    assign s_ready    = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign accept     = s_valid && s_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_func == OP_SEARCH && !is_empty) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (last_step) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control and result
    always_comb begin
        chain_mode      = CELL_HOLD;
        count_next      = count_reg;
        step_next       = step_reg;
        key_next        = key_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl[i].load = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_found_next  = 1'b0;
                    case (s_func)
                        OP_PUSH_FRONT: begin
                            if (is_full) begin
                                out_status_next = ST_OVERFLOW;
                            end else begin
                                chain_mode = CELL_FROM_PREV;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (is_full) begin
                                out_status_next = ST_OVERFLOW;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    cell_ctrl[i].load = (count_reg == CNT_W'(i));
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (is_empty) begin
                                out_status_next = ST_UNDERFLOW;
                            end else begin
                                chain_mode = CELL_FROM_NEXT;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (is_empty) begin
                                out_status_next = ST_UNDERFLOW;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            if (is_empty) begin
                                out_status_next = ST_EMPTY_SEARCH;
                            end else begin
                                // hold the result until the full rotation is done
                                out_valid_next = 1'b0;
                                key_next       = s_item_value;
                                step_next      = '0;
                                found_next     = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH: begin
                // rotate toward cell 0; after DEPTH steps order is restored
                chain_mode = CELL_FROM_NEXT;
                step_next  = step_reg + 1'b1;
                found_next = found_reg || search_hit;
                if (last_step) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_found_next  = found_reg || search_hit;
                end
            end
            default: ;
        endcase

        for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl[i].mode = chain_mode;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        deq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[g]),
            .load_data (s_item_value),
            .prev_data ((g == 0) ? s_item_value : cell_data[(g + DEPTH - 1) % DEPTH]),
            .next_data (cell_data[(g + 1) % DEPTH]),
            .data      (cell_data[g])
        );
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = out_status_reg;
    assign m_found     = out_found_reg;
    assign m_occupancy = OCC_W'(count_reg);

endmodule

// ----- hdl/deq_checker.sv -----
// Port-level checks for the deque with search, bound to the top level.
// Depends on deq_pkg and deque_with_search.
module deq_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_ready,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [deq_pkg::STAT_W-1:0]   m_status,
    input  logic                         m_found,
    input  logic [deq_pkg::OCC_W-1:0]    m_occupancy
);
    import deq_pkg::*;

    // a hit is only reported by a successful search
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_status == ST_OK))
        else $error("found set with non-ok status");

    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_UNDERFLOW || m_status == ST_EMPTY_SEARCH))
            |-> (m_occupancy == '0))
        else $error("empty status with non-zero occupancy");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_OVERFLOW) |-> (m_occupancy == OCC_W'(DEPTH)))
        else $error("overflow reported while not full");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_found)
            && $stable(m_occupancy)))
        else $error("stalled result changed");

    // a waiting result blocks the next item
    a_input_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input ready while a result waits");

endmodule

bind deque_with_search deq_checker u_deq_checker (.*);
